@@ rtl/core/dsa_pkg.sv @@
// shared types, constants and helpers for the dfa string acceptor
// no dependencies; imported by every module of the block but dsa_ram
package dsa_pkg;

  localparam int STATE_COUNT = 64;
  localparam int STATE_W     = 6;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = $clog2(STATE_COUNT);
  localparam int ADDR_W      = IDX_W + BYTE_W;
  localparam int TBL_DEPTH   = STATE_COUNT * (2 ** BYTE_W);
  localparam int ENTRY_W     = STATE_W + 1;

  localparam logic [BYTE_W-1:0] LINE_START = 8'd2;
  localparam logic [BYTE_W-1:0] LINE_END   = 8'd3;

  typedef enum logic [1:0] {
    OP_WR_EDGE   = 2'd0,
    OP_WR_ACCEPT = 2'd1,
    OP_TEXT      = 2'd2
  } opcode_t;

  typedef enum logic {
    CFG_START_STATE   = 1'b0,
    CFG_TABLE_PRESENT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] addr;
  } clr_t;

  function automatic logic state_ok(input logic [STATE_W-1:0] s);
    return (32'(s) < 32'(STATE_COUNT));
  endfunction

endpackage

@@ rtl/core/dsa_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// read-first on a same-address collision; no package dependencies
module dsa_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/dsa_clear.sv @@
// post-reset clearing sweep over the transition and accept stores
// depends on dsa_pkg for the address width and the clr_t bundle
module dsa_clear (
  input  logic          clk,
  input  logic          rst,
  output dsa_pkg::clr_t clr
);
  import dsa_pkg::*;

  logic              busy;
  logic [ADDR_W-1:0] addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      addr <= addr + 1'b1;
      if (addr == ADDR_W'(TBL_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign clr.busy = busy;
  assign clr.addr = addr;

endmodule

@@ rtl/core/dsa_match.sv @@
// byte walker: table read stage, state resolve with feedback, accept lookup, result beat
// depends on dsa_pkg; drives the read ports of both stores
module dsa_match (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr_busy,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [dsa_pkg::BYTE_W-1:0]   text_byte,
  input  logic                         last,
  input  logic [dsa_pkg::STATE_W-1:0]  start_state,
  input  logic                         table_present,
  output logic                         tbl_re,
  output logic [dsa_pkg::ADDR_W-1:0]   tbl_raddr,
  input  logic [dsa_pkg::ENTRY_W-1:0]  tbl_rdata,
  output logic                         acc_re,
  output logic [dsa_pkg::IDX_W-1:0]    acc_raddr,
  input  logic                         acc_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted
);
  import dsa_pkg::*;

  // committed string state
  logic [STATE_W-1:0] cur_state;
  logic               rejected;
  logic               in_string;

  // stage 1: byte whose table entry is on tbl_rdata
  logic               s1_valid;
  logic [STATE_W-1:0] s1_state;
  logic               s1_rej;
  logic [BYTE_W-1:0]  s1_byte;
  logic               s1_last;

  // stage 2: result beat
  logic               s2_ok;

  logic               s1_hold;
  logic               s1_adv;
  logic               text_fire;
  logic               edge_ok;
  logic [STATE_W-1:0] res_state;
  logic               res_rej;
  logic [STATE_W-1:0] src_state;
  logic               src_rej;
  logic               src_instr;
  logic [STATE_W-1:0] byte_state;
  logic               byte_rej;

  assign s1_hold   = s1_valid && s1_last && out_valid && !out_ready;
  assign s1_adv    = s1_valid && !s1_hold;
  assign in_ready  = !clr_busy && !s1_hold;
  assign text_fire = in_valid && in_ready && (opcode == OP_TEXT);

  // follow the edge; on a missing edge keep state for a line marker, else reject
  assign edge_ok = tbl_rdata[ENTRY_W-1] && state_ok(s1_state);

  always_comb begin
    res_state = s1_state;
    res_rej   = s1_rej;
    if (!s1_rej) begin
      if (edge_ok) begin
        res_state = tbl_rdata[STATE_W-1:0];
      end else if (s1_byte != LINE_START && s1_byte != LINE_END) begin
        res_rej = 1'b1;
      end
    end
  end

  // state forwarded from the byte in flight, else the committed one; start state opens a string
  always_comb begin
    if (s1_valid) begin
      src_state = res_state;
      src_rej   = res_rej;
      src_instr = !s1_last;
    end else begin
      src_state = cur_state;
      src_rej   = rejected;
      src_instr = in_string;
    end
    byte_state = src_instr ? src_state : start_state;
    byte_rej   = src_instr ? src_rej : 1'b0;
  end

  assign tbl_re    = text_fire;
  assign tbl_raddr = {byte_state[IDX_W-1:0], text_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_fire) begin
      s1_state <= byte_state;
      s1_rej   <= byte_rej;
      s1_byte  <= text_byte;
      s1_last  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= '0;
      rejected  <= 1'b0;
      in_string <= 1'b0;
    end else if (s1_adv) begin
      cur_state <= res_state;
      rejected  <= res_rej;
      in_string <= !s1_last;
    end
  end

  assign acc_re    = s1_adv && s1_last;
  assign acc_raddr = res_state[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc_re) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_re) begin
      s2_ok <= table_present && !res_rej && state_ok(res_state);
    end
  end

  assign accepted = s2_ok & acc_rdata;

  // a retiring last byte always raises a result beat, and only it raises one
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    acc_re |=> out_valid)
    else $error("result beat missing after last byte");

  // a stalled last byte blocks the input side
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_hold |-> !text_fire && s1_valid)
    else $error("input taken while last byte is stalled");

  // rejection is sticky within a string
  a_reject_sticky: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_rej) |-> res_rej && (res_state == s1_state))
    else $error("rejected string changed state");

endmodule

@@ rtl/core/dfa_string_acceptor_unit.sv @@
// top level of the table-driven dfa string acceptor
// depends on dsa_pkg, dsa_ram, dsa_clear and dsa_match
//
// Matches framed byte strings against a DFA held in on-chip stores: a 16384 x 7
// transition store (state, byte -> valid, next state) and a 64 x 1 accept store.
// Input beats either write one transition, write one accept flag, or carry one
// text byte; only a text byte with last set produces a result beat (accepted).
// After reset the block sweeps both stores to zero, one transition entry per
// cycle, with in_ready low; configuration writes are taken during the sweep.
// Afterwards it takes one beat per cycle unless a stalled last byte holds it:
// each text byte costs one transition store read, and the next byte's read
// address is formed directly from the registered read data of the previous
// byte, so strings stream at one byte per clock. A last byte adds one accept
// store read before its result beat appears. The result beat sits in an output
// register; input keeps flowing while it waits, and only a second last byte
// stalls until the first result is taken. Table writes take effect for the
// very next beat. Configuration (start_state, table_present) must only be
// written while no string result is outstanding.
module dfa_string_acceptor_unit (
  input  logic                         clk,
  input  logic                         rst,
  // input beats
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [dsa_pkg::STATE_W-1:0]  table_state,
  input  logic [dsa_pkg::BYTE_W-1:0]   edge_byte,
  input  logic [dsa_pkg::STATE_W-1:0]  edge_next_state,
  input  logic                         edge_valid,
  input  logic                         accept_flag,
  input  logic [dsa_pkg::BYTE_W-1:0]   text_byte,
  input  logic                         last,
  // result beats
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted,
  // configuration writes
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [dsa_pkg::STATE_W-1:0]  cfg_data
);
  import dsa_pkg::*;

  // configuration registers
  logic [STATE_W-1:0] start_state;
  logic               table_present;

  clr_t               clr;
  logic               in_fire;
  logic               wr_ok;

  logic               tbl_we;
  logic [ADDR_W-1:0]  tbl_waddr;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic               tbl_re;
  logic [ADDR_W-1:0]  tbl_raddr;
  logic [ENTRY_W-1:0] tbl_rdata;

  logic               acc_we;
  logic [IDX_W-1:0]   acc_waddr;
  logic               acc_wdata;
  logic               acc_re;
  logic [IDX_W-1:0]   acc_raddr;
  logic               acc_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state   <= '0;
      table_present <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_STATE:   start_state   <= cfg_data;
        CFG_TABLE_PRESENT: table_present <= cfg_data[0];
      endcase
    end
  end

  // table writes for states beyond the store are dropped
  assign in_fire = in_valid && in_ready;
  assign wr_ok   = in_fire && state_ok(table_state);

  // clearing sweep owns the write ports while busy
  always_comb begin
    if (clr.busy) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr.addr;
      tbl_wdata = '0;
      acc_we    = 1'b1;
      acc_waddr = clr.addr[IDX_W-1:0];
      acc_wdata = 1'b0;
    end else begin
      tbl_we    = wr_ok && (opcode == OP_WR_EDGE);
      tbl_waddr = {table_state[IDX_W-1:0], edge_byte};
      tbl_wdata = {edge_valid, edge_next_state};
      acc_we    = wr_ok && (opcode == OP_WR_ACCEPT);
      acc_waddr = table_state[IDX_W-1:0];
      acc_wdata = accept_flag;
    end
  end

  dsa_clear u_clear (
    .clk (clk),
    .rst (rst),
    .clr (clr)
  );

  dsa_ram #(
    .DEPTH (TBL_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  dsa_ram #(
    .DEPTH (STATE_COUNT),
    .WIDTH (1)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  dsa_match u_match (
    .clk           (clk),
    .rst           (rst),
    .clr_busy      (clr.busy),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .text_byte     (text_byte),
    .last          (last),
    .start_state   (start_state),
    .table_present (table_present),
    .tbl_re        (tbl_re),
    .tbl_raddr     (tbl_raddr),
    .tbl_rdata     (tbl_rdata),
    .acc_re        (acc_re),
    .acc_raddr     (acc_raddr),
    .acc_rdata     (acc_rdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted)
  );

endmodule

@@ tb/dfa_string_acceptor_unit_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for dfa_string_acceptor_unit: directed strings, then random automata
// and framed strings under varied idling; depends on dsa_pkg and the rtl of the block
module dfa_string_acceptor_unit_test;
  import dsa_pkg::*;

  // opcode left unused by the block, it must be swallowed without a result
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // reset sweep plus a few thousand slow beats, taken many times over
  localparam int CYCLE_LIMIT = 400000;
  // a little margin for beats still in flight
  localparam int SETTLE_CYCLES = 4;
  localparam int STRINGS_PER_AUTOMATON = 30;

  // one input beat, field by field
  typedef struct packed {
    logic [1:0]         op;
    logic [STATE_W-1:0] tstate;
    logic [BYTE_W-1:0]  ebyte;
    logic [STATE_W-1:0] enext;
    logic               evalid;
    logic               aflag;
    logic [BYTE_W-1:0]  tbyte;
    logic               last_flag;
  } dfa_item_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          opcode;
  logic [STATE_W-1:0]  table_state;
  logic [BYTE_W-1:0]   edge_byte;
  logic [STATE_W-1:0]  edge_next_state;
  logic                edge_valid;
  logic                accept_flag;
  logic [BYTE_W-1:0]   text_byte;
  logic                last;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                accepted;
  logic                cfg_we;
  logic                cfg_index;
  logic [STATE_W-1:0]  cfg_data;

  // predicted copy of the automaton and the walk through it
  bit [ENTRY_W-1:0]    edge_mem [0:TBL_DEPTH-1];
  bit                  accept_mem [0:STATE_COUNT-1];
  logic [STATE_W-1:0]  cur_state;
  bit                  dead;
  bit                  mid_string;
  logic [STATE_W-1:0]  start_cfg;
  bit                  present_cfg;

  // accept answers still owed by the block, oldest first
  bit                  accept_due [$];

  // automaton currently used to shape the random strings
  logic [STATE_W-1:0]  dfa_states [$];
  logic [BYTE_W-1:0]   dfa_bytes [$];

  int                  send_idle;
  int                  recv_idle;
  int                  items_sent;
  int                  err_count;
  int                  cycle_count;

  dfa_string_acceptor_unit uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .table_state     (table_state),
    .edge_byte       (edge_byte),
    .edge_next_state (edge_next_state),
    .edge_valid      (edge_valid),
    .accept_flag     (accept_flag),
    .text_byte       (text_byte),
    .last            (last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL dfa_string_acceptor_unit");
      $finish;
    end
  end

  // result side backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("error at %0t: %s", $realtime, msg);
  endfunction

  // compare every result beat with the oldest owed answer
  always @(posedge clk) begin
    bit want;
    if (!rst && out_valid && out_ready) begin
      if (accept_due.size() == 0) begin
        note_error($sformatf("result beat with nothing owed, accepted=%0b", accepted));
      end else begin
        want = accept_due.pop_front();
        if (accepted !== want)
          note_error($sformatf("accepted: expected %0b, got %0b", want, accepted));
      end
    end
  end

  // predictor: apply one accepted beat to the copy of the automaton
  function automatic void step_dfa(input dfa_item_t it);
    logic [ENTRY_W-1:0] entry;
    case (it.op)
      OP_WR_EDGE:   edge_mem[{it.tstate, it.ebyte}] = {it.evalid, it.enext};
      OP_WR_ACCEPT: accept_mem[it.tstate] = it.aflag;
      OP_TEXT: begin
        // first byte of a string restarts the walk
        if (!mid_string) begin
          cur_state  = start_cfg;
          dead       = 1'b0;
          mid_string = 1'b1;
        end
        if (!dead) begin
          entry = edge_mem[{cur_state, it.tbyte}];
          if (entry[ENTRY_W-1]) cur_state = entry[STATE_W-1:0];
          // line markers with no edge leave the state alone
          else if (it.tbyte != LINE_START && it.tbyte != LINE_END) dead = 1'b1;
        end
        if (it.last_flag) begin
          mid_string = 1'b0;
          accept_due.push_back(present_cfg && !dead && accept_mem[cur_state]);
        end
      end
      default: ;
    endcase
  endfunction

  // beat with every field random, opcode included
  function automatic dfa_item_t rand_item();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(dfa_item_t)-1:0];
  endfunction

  function automatic dfa_item_t text_item(input logic [BYTE_W-1:0] b, input logic l);
    dfa_item_t it;
    it           = rand_item();
    it.op        = OP_TEXT;
    it.tbyte     = b;
    it.last_flag = l;
    return it;
  endfunction

  function automatic dfa_item_t edge_item(input logic [STATE_W-1:0] s,
                                          input logic [BYTE_W-1:0] b,
                                          input logic [STATE_W-1:0] n, input logic v);
    dfa_item_t it;
    it        = rand_item();
    it.op     = OP_WR_EDGE;
    it.tstate = s;
    it.ebyte  = b;
    it.enext  = n;
    it.evalid = v;
    return it;
  endfunction

  function automatic dfa_item_t flag_item(input logic [STATE_W-1:0] s, input logic f);
    dfa_item_t it;
    it        = rand_item();
    it.op     = OP_WR_ACCEPT;
    it.tstate = s;
    it.aflag  = f;
    return it;
  endfunction

  function automatic dfa_item_t unused_item();
    dfa_item_t it;
    it    = rand_item();
    it.op = OP_UNUSED;
    return it;
  endfunction

  // entered and left at a falling edge; valid stays up when the next beat follows at once,
  // so every other time-consuming task lowers it first
  task automatic send_beat(input dfa_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    opcode          <= it.op;
    table_state     <= it.tstate;
    edge_byte       <= it.ebyte;
    edge_next_state <= it.enext;
    edge_valid      <= it.evalid;
    accept_flag     <= it.aflag;
    text_byte       <= it.tbyte;
    last            <= it.last_flag;
    do @(posedge clk); while (!in_ready);
    step_dfa(it);
    if (it.op != OP_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // hold input until every owed answer is back, then let in-flight beats settle
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (accept_due.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // both registers, only with no string open and nothing owed
  task automatic set_config(input logic [STATE_W-1:0] start, input bit present);
    if (mid_string) send_beat(text_item(8'($urandom_range(0, 255)), 1'b1));
    wait_drained(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_STATE;
    cfg_data  <= start;
    @(negedge clk);
    // upper data bits are don't-care for the one-bit register
    cfg_index <= CFG_TABLE_PRESENT;
    cfg_data  <= {5'($urandom_range(0, 31)), present};
    @(negedge clk);
    cfg_we      <= 1'b0;
    start_cfg   = start;
    present_cfg = present;
  endtask

  // small random automaton rooted at the start state, over a few byte values
  task automatic load_dfa();
    int k;
    int a;
    dfa_states.delete();
    dfa_bytes.delete();
    k = $urandom_range(2, 8);
    a = $urandom_range(2, 6);
    dfa_states.push_back(start_cfg);
    repeat (k - 1) dfa_states.push_back(6'($urandom_range(0, 63)));
    repeat (a) dfa_bytes.push_back(8'($urandom_range(0, 255)));
    foreach (dfa_states[i]) begin
      send_beat(flag_item(dfa_states[i], 1'($urandom_range(0, 1))));
      foreach (dfa_bytes[j])
        send_beat(edge_item(dfa_states[i], dfa_bytes[j], dfa_states[$urandom_range(0, k - 1)],
                            $urandom_range(0, 9) != 0));
    end
  endtask

  // mostly framed strings over the automaton's bytes, with stray bytes, table edits and noise
  task automatic send_string();
    int  len;
    int  r;
    bit  framed;
    logic [BYTE_W-1:0] b;
    len    = $urandom_range(0, 8);
    framed = ($urandom_range(0, 19) != 0);
    if (framed) send_beat(text_item(LINE_START, 1'b0));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        send_beat(edge_item(dfa_states[$urandom_range(0, dfa_states.size() - 1)],
                            dfa_bytes[$urandom_range(0, dfa_bytes.size() - 1)],
                            dfa_states[$urandom_range(0, dfa_states.size() - 1)],
                            1'($urandom_range(0, 1))));
      else if (r < 5)
        send_beat(flag_item(dfa_states[$urandom_range(0, dfa_states.size() - 1)],
                            1'($urandom_range(0, 1))));
      else if (r < 8)
        send_beat($urandom_range(0, 1) ? unused_item() : rand_item());
      b = (r < 14) ? 8'($urandom_range(0, 255))
                   : dfa_bytes[$urandom_range(0, dfa_bytes.size() - 1)];
      send_beat(text_item(b, !framed && i == len - 1));
    end
    if (framed) send_beat(text_item(LINE_END, 1'b1));
    else if (len == 0) send_beat(text_item(8'($urandom_range(0, 255)), 1'b1));
  endtask

  // reset config: table flagged absent, so even an accepting start answers zero
  task automatic test_table_absent();
    send_beat(flag_item(6'd0, 1'b1));
    send_beat(text_item(LINE_START, 1'b0));
    send_beat(text_item(LINE_END, 1'b1));
  endtask

  // markers with no edge keep the state; an ordinary byte with no edge rejects
  task automatic test_markers_without_edges();
    set_config(6'd0, 1'b1);
    send_beat(text_item(LINE_START, 1'b0));
    send_beat(text_item(LINE_END, 1'b1));
    send_beat(text_item(8'h61, 1'b1));
  endtask

  // top state and byte values, then an edge removed by a second write to it
  task automatic test_extreme_states();
    set_config(6'd63, 1'b1);
    send_beat(edge_item(6'd63, 8'hff, 6'd0, 1'b1));
    send_beat(edge_item(6'd0, 8'h00, 6'd63, 1'b1));
    send_beat(flag_item(6'd63, 1'b1));
    send_beat(flag_item(6'd0, 1'b0));
    send_beat(text_item(LINE_START, 1'b0));
    send_beat(text_item(8'hff, 1'b0));
    send_beat(text_item(8'h00, 1'b0));
    send_beat(text_item(LINE_END, 1'b1));
    send_beat(edge_item(6'd0, 8'h00, 6'd63, 1'b0));
    send_beat(text_item(8'hff, 1'b0));
    send_beat(text_item(8'h00, 1'b1));
  endtask

  // once rejected, the string stays rejected even if it ends in an accepting state
  task automatic test_rejection_sticks();
    send_beat(text_item(8'h55, 1'b0));
    send_beat(text_item(LINE_END, 1'b1));
  endtask

  // an edge written inside a string is used by the very next byte; unused opcode in between
  task automatic test_write_mid_string();
    send_beat(text_item(LINE_START, 1'b0));
    send_beat(edge_item(6'd63, 8'h41, 6'd63, 1'b1));
    send_beat(unused_item());
    send_beat(text_item(8'h41, 1'b0));
    send_beat(text_item(LINE_END, 1'b1));
  endtask

  // a marker that has an edge is followed; then one-byte strings back to back
  task automatic test_marker_edge_back_to_back();
    send_beat(edge_item(6'd63, LINE_START, 6'd0, 1'b1));
    send_beat(text_item(LINE_START, 1'b1));
    send_beat(text_item(LINE_END, 1'b1));
    send_beat(text_item(LINE_END, 1'b1));
  endtask

  // random automata and strings until about n_items counted beats went in
  task automatic test_random_strings(input int n_items, input bit pause_midway);
    int goal;
    int nstr;
    bit paused;
    goal   = items_sent + n_items;
    nstr   = 0;
    paused = !pause_midway;
    while (items_sent < goal) begin
      if (nstr % STRINGS_PER_AUTOMATON == 0) load_dfa();
      send_string();
      nstr++;
      // sender holds off until every owed answer is back
      if (!paused && items_sent >= goal - n_items / 2) begin
        wait_drained(0);
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    // every input known from time zero
    rst             = 1'b1;
    in_valid        = 1'b0;
    opcode          = OP_WR_EDGE;
    table_state     = '0;
    edge_byte       = '0;
    edge_next_state = '0;
    edge_valid      = 1'b0;
    accept_flag     = 1'b0;
    text_byte       = '0;
    last            = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_START_STATE;
    cfg_data        = '0;
    cycle_count     = 0;
    err_count       = 0;
    items_sent      = 0;
    cur_state       = '0;
    dead            = 1'b0;
    mid_string      = 1'b0;
    start_cfg       = '0;
    present_cfg     = 1'b0;
    send_idle       = 13;
    recv_idle       = 70;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // the store sweep after reset holds in_ready low; send_beat simply waits it out

    test_table_absent();
    test_markers_without_edges();
    test_extreme_states();
    test_rejection_sticks();
    test_write_mid_string();
    test_marker_edge_back_to_back();

    set_config(6'($urandom_range(0, 63)), 1'b1);
    test_random_strings(600, 1'b1);

    set_config(6'd63, 1'b1);
    send_idle = 70;
    recv_idle = 13;
    test_random_strings(600, 1'b0);

    set_config(6'd0, 1'b1);
    send_idle = 0;
    recv_idle = 0;
    test_random_strings(600, 1'b0);

    wait_drained(4 * SETTLE_CYCLES);
    if (err_count == 0 && accept_due.size() == 0)
      $display("PASS dfa_string_acceptor_unit");
    else
      $display("FAIL dfa_string_acceptor_unit");
    $finish;
  end

endmodule

@@ dfa_string_acceptor_unit.f @@
rtl/core/dsa_pkg.sv
rtl/core/dsa_ram.sv
rtl/core/dsa_clear.sv
rtl/core/dsa_match.sv
rtl/core/dfa_string_acceptor_unit.sv
tb/dfa_string_acceptor_unit_test.sv
